>>> hdl/osb_pkg.sv
// ----------------------------------------------------------------------------
// osb_pkg
// Shared types, constants and the quarter-wave sine table of the oscillator bank.
// ----------------------------------------------------------------------------
package osb_pkg;

  // bank geometry
  localparam int VOICES       = 512;
  localparam int SINE_ENTRIES = 1024;  // power of two
  localparam int PHASE_BITS   = 24;

  localparam int VOICE_BITS = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SINE_BITS  = $clog2(SINE_ENTRIES);
  localparam int QTR_BITS   = SINE_BITS - 2;
  localparam int QTR        = 1 << QTR_BITS;
  localparam int QIDX_BITS  = QTR_BITS + 1;

  // field widths
  localparam int STEP_BITS     = 24;
  localparam int AMP_BITS      = 21;
  localparam int AMP_ONE       = 1 << 20;
  localparam int SAMPLE_BITS   = 24;
  localparam int SINE_MAG_BITS = 15;
  localparam int BRIGHT_BITS   = 8;
  localparam int BRIGHT_MAX    = 255;
  localparam int CFG_IDX_BITS  = 2;

  // register reset values
  localparam logic [STEP_BITS-1:0] LOW_STEP_RST  = 24'd38448;
  localparam logic [STEP_BITS-1:0] HIGH_STEP_RST = 24'd153791;
  localparam logic [AMP_BITS-1:0]  FADE_IN_RST   = 21'd1049;
  localparam logic [AMP_BITS-1:0]  FADE_OUT_RST  = 21'd105;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_STEP  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_STEP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_IN   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_OUT  = 2'd3;

  // opcodes
  localparam logic OP_TRIGGER = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [8:0]             voice_index;
    logic [BRIGHT_BITS-1:0] brightness;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
  } result_t;

  typedef struct packed {
    logic [STEP_BITS-1:0]  step;
    logic [PHASE_BITS-1:0] phase;
    logic [AMP_BITS-1:0]   amp;
    logic                  fading;
  } voice_t;

  // trigger step calculation request and status
  typedef struct packed {
    logic                   go;
    logic [BRIGHT_BITS-1:0] brightness;
    logic [STEP_BITS-1:0]   low;
    logic [STEP_BITS-1:0]   high;
  } step_req_t;

  typedef struct packed {
    logic                 done;
    logic [STEP_BITS-1:0] step;
  } step_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRIG,
    ST_TICK,
    ST_DRAIN,
    ST_OUT
  } seq_state_t;

  typedef logic [SINE_MAG_BITS-1:0] sine_mag_t;
  typedef sine_mag_t sine_rom_t [QTR+1];

  // sin(pi/2 * z), z and result in Q30, odd 9th order polynomial
  function automatic longint unsigned quarter_sine(input longint unsigned z);
    longint unsigned z2;
    longint unsigned p;
    z2 = (z * z) >> 30;
    p  = 64'd172272;
    p  = 64'd5026996 - ((z2 * p) >> 30);
    p  = 64'd85569306 - ((z2 * p) >> 30);
    p  = 64'd693598669 - ((z2 * p) >> 30);
    p  = 64'd1686629713 - ((z2 * p) >> 30);
    return (z * p) >> 30;
  endfunction

  // magnitude table over the first quarter, end point included
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned z;
    longint unsigned s;
    longint unsigned v;
    for (int i = 0; i <= QTR; i++) begin
      z = longint'(i) << (30 - QTR_BITS);
      s = quarter_sine(z);
      v = (s * 64'd32768 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[i] = SINE_MAG_BITS'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> hdl/osb_step_calc.sv
// ----------------------------------------------------------------------------
// osb_step_calc
// Maps a brightness onto a phase step: low + (high - low) * b / 255,
// truncated toward zero, on one shared multiplier: the product, then a
// reciprocal multiply for the divide by 255.
// ----------------------------------------------------------------------------
module osb_step_calc
  import osb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  step_req_t  req,
  output step_stat_t stat
);

  localparam int DIVD_BITS   = STEP_BITS + BRIGHT_BITS;
  localparam int MUL_BITS    = 2 * DIVD_BITS;
  // ceil(2^39 / 255) gives the exact quotient for any 32 bit dividend
  localparam int RECIP_SHIFT = 39;
  localparam logic [DIVD_BITS-1:0] RECIP =
    DIVD_BITS'(((64'd1 << RECIP_SHIFT) + BRIGHT_MAX - 1) / BRIGHT_MAX);
  localparam logic [1:0] CNT_PROD  = 2'd0;
  localparam logic [1:0] CNT_RECIP = 2'd1;
  localparam logic [1:0] CNT_LAST  = 2'd2;

  logic                   run;
  logic                   done;
  logic [1:0]             cnt;
  logic [STEP_BITS-1:0]   absd;
  logic                   neg;
  logic [BRIGHT_BITS-1:0] bright;
  logic [DIVD_BITS-1:0]   prod;
  logic [STEP_BITS-1:0]   quot;
  logic [STEP_BITS-1:0]   step;

  logic [STEP_BITS:0]     diff;
  logic [DIVD_BITS-1:0]   mul_a;
  logic [DIVD_BITS-1:0]   mul_b;
  logic [MUL_BITS-1:0]    mul_p;
  logic [STEP_BITS-1:0]   quot_sgn;

  // one multiplier: difference times brightness, then times the reciprocal
  always_comb begin
    diff = {1'b0, req.high} - {1'b0, req.low};
    if (cnt == CNT_PROD) begin
      mul_a = DIVD_BITS'(absd);
      mul_b = DIVD_BITS'(bright);
    end else begin
      mul_a = prod;
      mul_b = RECIP;
    end
    mul_p    = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);
    quot_sgn = neg ? (~quot + STEP_BITS'(1)) : quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 2'(1);
        if (cnt == CNT_LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (req.go) begin
      neg    <= diff[STEP_BITS];
      absd   <= diff[STEP_BITS] ? STEP_BITS'(~diff + 1'b1) : diff[STEP_BITS-1:0];
      bright <= req.brightness;
    end else if (run) begin
      case (cnt)
        CNT_PROD:  prod <= mul_p[DIVD_BITS-1:0];
        CNT_RECIP: quot <= mul_p[RECIP_SHIFT +: STEP_BITS];
        CNT_LAST:  step <= req.low + quot_sgn;
        default:   ;
      endcase
    end
  end

  assign stat.done = done;
  assign stat.step = step;

endmodule

>>> hdl/oscillator_bank_with_fade_envelopes.sv
// ----------------------------------------------------------------------------
// oscillator_bank_with_fade_envelopes
// Tick: the voices run one voice per cycle through the voice memory and a three
// stage envelope, sine and multiply pipe into the sum; the result comes later
// when the last voices sound, and busy stays high until the result strobe.
// Trigger: no result, busy through product, reciprocal divide, add and write.
// Reset: a clearing sweep through every voice of the voice memory, busy high
// meanwhile; the result strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module oscillator_bank_with_fade_envelopes
  import osb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // command side
  input  logic                    start,
  output logic                    busy,
  input  cmd_t                    cmd,
  // result side
  output logic                    result_valid,
  output result_t                 result,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [STEP_BITS-1:0]    cfg_data
);

  // sum wide enough for every voice at full scale
  localparam int SUM_W0   = $clog2(VOICES + 1) + 16;
  localparam int SUM_BITS = (SUM_W0 > SAMPLE_BITS + 1) ? SUM_W0 : SAMPLE_BITS + 1;
  localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);
  localparam logic [VOICE_BITS-1:0] VOICE_LAST = VOICE_BITS'(VOICES - 1);
  localparam int PROD_BITS = SINE_MAG_BITS + AMP_BITS;

  // configuration registers
  logic [STEP_BITS-1:0] low_freq_step;
  logic [STEP_BITS-1:0] high_freq_step;
  logic [AMP_BITS-1:0]  fade_in_step;
  logic [AMP_BITS-1:0]  fade_out_step;

  // sequencer
  seq_state_t           state;
  seq_state_t           state_next;
  logic [VOICE_BITS-1:0] vcnt;
  cmd_t                 cmd_q;
  logic                 accept;
  logic                 trig_ok;

  // voice memory
  voice_t               vmem [VOICES];
  voice_t               rdata;
  logic                 mem_we;
  logic [VOICE_BITS-1:0] mem_waddr;
  logic [VOICE_BITS-1:0] mem_raddr;
  voice_t               mem_wdata;

  // trigger step unit
  step_req_t            step_req;
  step_stat_t           step_stat;
  logic                 step_go;

  // pipe stage 1: envelope, sine lookup, phase advance
  logic                 s1_valid;
  logic [VOICE_BITS-1:0] s1_addr;
  logic                 s1_active;
  logic signed [AMP_BITS+1:0] s1_env;
  logic [AMP_BITS-1:0]  s1_amp;
  logic                 s1_fading;
  logic [SINE_BITS-1:0] s1_k;
  logic [QIDX_BITS-1:0] s1_fidx;
  voice_t               s1_wdata;

  // pipe stage 2: multiply
  logic                 s2_valid;
  logic                 s2_neg;
  sine_mag_t            s2_mag;
  logic [AMP_BITS-1:0]  s2_amp;
  logic [PROD_BITS-1:0] s2_prod;

  // pipe stage 3: accumulate
  logic                 s3_valid;
  logic                 s3_neg;
  logic [SINE_MAG_BITS-1:0] s3_contrib;
  logic signed [SUM_BITS-1:0] sum;
  logic signed [SUM_BITS-1:0] contrib_ext;
  logic signed [SUM_BITS-1:0] sat;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign trig_ok   = (32'(cmd.voice_index) < VOICES);
  assign cfg_ready = 1'b1;

  // configuration transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      low_freq_step  <= LOW_STEP_RST;
      high_freq_step <= HIGH_STEP_RST;
      fade_in_step   <= FADE_IN_RST;
      fade_out_step  <= FADE_OUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOW_STEP:  low_freq_step  <= cfg_data;
        CFG_HIGH_STEP: high_freq_step <= cfg_data;
        CFG_FADE_IN:   fade_in_step   <= cfg_data[AMP_BITS-1:0];
        CFG_FADE_OUT:  fade_out_step  <= cfg_data[AMP_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (vcnt == VOICE_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd.opcode == OP_TICK) begin
            state_next = ST_TICK;
          end else if (trig_ok) begin
            state_next = ST_TRIG;
          end
        end
      end
      ST_TRIG: begin
        if (step_stat.done) state_next = ST_IDLE;
      end
      ST_TICK: begin
        if (vcnt == VOICE_LAST) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid && !s3_valid) state_next = ST_OUT;
      end
      ST_OUT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs: memory port, step unit start and result strobe
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = s1_addr;
    mem_wdata    = s1_wdata;
    mem_raddr    = vcnt;
    step_go      = 1'b0;
    result_valid = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = vcnt;
        mem_wdata.step  = LOW_STEP_RST;
        mem_wdata.phase = '0;
        mem_wdata.amp   = '0;
        mem_wdata.fading = 1'b0;
      end
      ST_IDLE: begin
        step_go = accept && (cmd.opcode == OP_TRIGGER) && trig_ok;
      end
      ST_TRIG: begin
        // rewrite the voice: new step, phase kept, silent and fading in
        mem_raddr        = VOICE_BITS'(cmd_q.voice_index);
        mem_waddr        = VOICE_BITS'(cmd_q.voice_index);
        mem_we           = step_stat.done;
        mem_wdata.step   = step_stat.step;
        mem_wdata.phase  = rdata.phase;
        mem_wdata.amp    = '0;
        mem_wdata.fading = 1'b1;
      end
      ST_TICK, ST_DRAIN: begin
        mem_we = s1_valid && s1_active;
      end
      ST_OUT: begin
        result_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      vcnt     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      state    <= state_next;
      if (state == ST_CLEAR || state == ST_TICK) begin
        vcnt <= (vcnt == VOICE_LAST) ? '0 : vcnt + VOICE_BITS'(1);
      end
      s1_valid <= (state == ST_TICK);
      // silent voices leave the pipe here
      s2_valid <= s1_valid && s1_active;
      s3_valid <= s2_valid;
    end
  end

  // voice memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[mem_waddr] <= mem_wdata;
    end
    rdata <= vmem[mem_raddr];
  end

  assign step_req.go         = step_go;
  assign step_req.brightness = cmd.brightness;
  assign step_req.low        = low_freq_step;
  assign step_req.high       = high_freq_step;

  osb_step_calc u_step_calc (
    .clk  (clk),
    .rst  (rst),
    .req  (step_req),
    .stat (step_stat)
  );

  // stage 1: envelope update, quarter-wave fold and phase advance
  always_comb begin
    s1_active = (rdata.amp != '0) || rdata.fading;
    if (rdata.fading) begin
      s1_env = $signed({2'b00, rdata.amp}) + $signed({2'b00, fade_in_step});
    end else begin
      s1_env = $signed({2'b00, rdata.amp}) - $signed({2'b00, fade_out_step});
    end
    // fade-in ends once the raw level reaches full scale
    s1_fading = rdata.fading && (s1_env < (AMP_BITS+2)'(AMP_ONE));
    if (s1_env < 0) begin
      s1_amp = '0;
    end else if (s1_env > (AMP_BITS+2)'(AMP_ONE)) begin
      s1_amp = AMP_BITS'(AMP_ONE);
    end else begin
      s1_amp = s1_env[AMP_BITS-1:0];
    end
    s1_k = rdata.phase[PHASE_BITS-1 -: SINE_BITS];
    // odd quadrants run the table backwards
    if (s1_k[QTR_BITS]) begin
      s1_fidx = QIDX_BITS'(QTR) - {1'b0, s1_k[QTR_BITS-1:0]};
    end else begin
      s1_fidx = {1'b0, s1_k[QTR_BITS-1:0]};
    end
    s1_wdata.step   = rdata.step;
    s1_wdata.phase  = rdata.phase + PHASE_BITS'(rdata.step);
    s1_wdata.amp    = s1_amp;
    s1_wdata.fading = s1_fading;
  end

  always_ff @(posedge clk) begin
    s1_addr <= vcnt;
    s2_neg  <= s1_k[SINE_BITS-1];
    s2_mag  <= SINE_ROM[s1_fidx];
    s2_amp  <= s1_amp;
  end

  // stage 2: half of sine times amplitude, magnitude only
  assign s2_prod = PROD_BITS'(s2_mag) * PROD_BITS'(s2_amp);

  always_ff @(posedge clk) begin
    s3_neg     <= s2_neg;
    s3_contrib <= s2_prod[PROD_BITS-1 -: SINE_MAG_BITS];
  end

  // stage 3: exact accumulate, cleared when a tick is taken
  assign contrib_ext = $signed(SUM_BITS'(s3_contrib));

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (accept && cmd.opcode == OP_TICK) begin
      sum <= '0;
    end else if (s3_valid) begin
      sum <= s3_neg ? sum - contrib_ext : sum + contrib_ext;
    end
  end

  // saturate to the sample range, both channels identical
  always_comb begin
    if (sum > SAT_HI) begin
      sat = SAT_HI;
    end else if (sum < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = sum;
    end
  end

  assign result.sample_left  = sat[SAMPLE_BITS-1:0];
  assign result.sample_right = sat[SAMPLE_BITS-1:0];

`ifndef SYNTHESIS
  // result only once the pipe has fully drained into the sum
  a_result_drained: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!s1_valid && !s2_valid && !s3_valid))
    else $error("result strobe with voices still in flight");

  // no voice memory write while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("voice memory written while idle");

  // step unit only finishes while a trigger waits for it
  a_step_done_trig: assert property (@(posedge clk) disable iff (rst)
    step_stat.done |-> (state == ST_TRIG))
    else $error("step unit finished outside a trigger");

  // a result strobe lasts one cycle
  a_result_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");
`endif

endmodule
